/* rtl/wsa_pkg.sv */
// wsa_pkg: shared types and codes for the windowed sample average block.
// Used by every module under rtl/; depends on nothing.
package wsa_pkg;

  // operation codes
  localparam logic OP_PUSH  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  // averaging kinds (kind 3 behaves as plain)
  localparam logic [1:0] KIND_PLAIN  = 2'd0;
  localparam logic [1:0] KIND_OFFSET = 2'd1;
  localparam logic [1:0] KIND_DEV    = 2'd2;
  localparam logic [1:0] KIND_SPARE  = 2'd3;

  // register indexes
  localparam logic REG_REFERENCE = 1'b0;
  localparam logic REG_FILL      = 1'b1;

  localparam logic signed [15:0] LEVEL_ONE = 16'sd4096;  // 1.0 in Q3.12

  // classified request held in the queue
  typedef struct packed {
    logic               op;
    logic signed [15:0] sample;
    logic signed [11:0] start_index;
    logic [10:0]        window_length;
    logic [1:0]         average_kind;
    logic               win_err;
  } cmd_t;

  // configuration seen by the execution side
  typedef struct packed {
    logic signed [15:0] reference_level;
    logic signed [15:0] fill_value;
    logic               refill;
  } cfg_t;

endpackage

/* rtl/wsa_front.sv */
// wsa_front: accepts input requests, classifies them and enqueues them.
// Depends on wsa_pkg.
module wsa_front #(
  parameter int DEPTH = 1024
) (
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_op,
  input  logic signed [15:0] in_sample,
  input  logic signed [11:0] in_start_index,
  input  logic [10:0]        in_window_length,
  input  logic [1:0]         in_average_kind,
  input  logic               clearing,
  input  logic               q_full,
  output logic               q_push,
  output wsa_pkg::cmd_t      q_data
);

  logic win_bad;

  // window of zero or wider than the ring is flagged up front
  assign win_bad = (in_window_length == 11'd0) ||
                   ({21'd0, in_window_length} > 32'(DEPTH));

  assign in_ready = !q_full && !clearing;
  assign q_push   = in_valid && in_ready;

  always_comb begin
    q_data.op            = in_op;
    q_data.sample        = in_sample;
    q_data.start_index   = in_start_index;
    q_data.window_length = in_window_length;
    q_data.average_kind  = in_average_kind;
    q_data.win_err       = (in_op == wsa_pkg::OP_QUERY) && win_bad;
  end

endmodule

/* rtl/wsa_queue.sv */
// wsa_queue: two-entry request queue between front and execution side.
// Depends on wsa_pkg.
module wsa_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  wsa_pkg::cmd_t push_data,
  output logic          full,
  input  logic          pop,
  output logic          valid,
  output wsa_pkg::cmd_t pop_data
);

  wsa_pkg::cmd_t entry_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;

  assign full     = (cnt_r == 2'd2);
  assign valid    = (cnt_r != 2'd0);
  assign pop_data = entry_r[rd_ptr_r];

  // pointer and count update
  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop  ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // payload storage
  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

/* rtl/wsa_back.sv */
// wsa_back: executes queued requests: ring memory, refill sweep, window
// reduction, summation, serial divide and the result register. Depends on wsa_pkg.
module wsa_back #(
  parameter int DEPTH = 1024
) (
  input  logic               clk,
  input  logic               rst_n,
  input  wsa_pkg::cfg_t      cfg,
  input  logic               q_valid,
  input  wsa_pkg::cmd_t      q_data,
  output logic               q_pop,
  output logic               clearing,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] out_window_mean,
  output logic               out_window_error,
  output logic [9:0]         out_newest_index
);

  localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RED  = 3'd1;
  localparam logic [2:0] S_SUM  = 3'd2;
  localparam logic [2:0] S_DIV  = 3'd3;
  localparam logic [2:0] S_RES  = 3'd4;

  logic [15:0] mem [DEPTH];
  logic [15:0] rdata_r;

  logic [2:0]  state_r, state_nxt;
  logic        clr_r, clr_nxt;
  logic [IW-1:0] clr_cnt_r, clr_cnt_nxt;
  logic [IW-1:0] wi_r, wi_nxt;
  logic [IW-1:0] pos_r, pos_nxt;
  logic [1:0]  kind_r, kind_nxt;
  logic [10:0] win_r, win_nxt;
  logic        neg_start_r, neg_start_nxt;
  logic [11:0] rem_r, rem_nxt;
  logic [4:0]  step_r, step_nxt;
  logic [10:0] iss_r, iss_nxt;
  logic        rd_vld_r, rd_vld_nxt;
  logic signed [28:0] acc_r, acc_nxt;
  logic [27:0] dvd_r, dvd_nxt;
  logic [27:0] quo_r, quo_nxt;
  logic [11:0] drem_r, drem_nxt;
  logic        neg_r, neg_nxt;
  logic        err_r, err_nxt;

  logic        out_valid_r;
  logic signed [15:0] mean_r;
  logic        oerr_r;
  logic [9:0]  newest_r;

  logic        mem_we;
  logic [IW-1:0] mem_wa;
  logic [15:0] mem_wd;
  logic        slot_free;
  logic        load_out;
  logic signed [15:0] mean_val;

  logic [IW-1:0] wi_inc, pos_inc;
  logic [31:0] red_cmp;
  logic [11:0] red_rem;
  logic signed [17:0] term, diff;
  logic [12:0] dshift;

  assign slot_free = !out_valid_r || out_ready;
  assign clearing  = clr_r;
  assign wi_inc    = (wi_r == IW'(DEPTH - 1)) ? '0 : wi_r + 1'b1;
  assign pos_inc   = (pos_r == IW'(DEPTH - 1)) ? '0 : pos_r + 1'b1;

  // one restoring step of |start| mod DEPTH
  always_comb begin
    red_cmp = 32'(DEPTH) << step_r;
    red_rem = ({20'd0, rem_r} >= red_cmp) ? rem_r - 12'(red_cmp) : rem_r;
  end

  // per-entry term from the registered read data
  always_comb begin
    diff = 18'(signed'(rdata_r)) - 18'(cfg.reference_level);
    case (kind_r)
      wsa_pkg::KIND_OFFSET: term = diff;
      wsa_pkg::KIND_DEV:    term = diff[17] ? -diff : diff;
      default:              term = 18'(signed'(rdata_r));
    endcase
  end

  assign dshift = {drem_r, dvd_r[27]};

  // signed, saturated mean from the magnitude quotient
  always_comb begin
    if (err_r) begin
      mean_val = '0;
    end else if (!neg_r && quo_r > 28'd32767) begin
      mean_val = 16'sh7fff;
    end else if (neg_r && quo_r > 28'd32768) begin
      mean_val = 16'sh8000;
    end else begin
      mean_val = neg_r ? 16'(-quo_r) : 16'(quo_r);
    end
  end

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    clr_nxt       = clr_r;
    clr_cnt_nxt   = clr_cnt_r;
    wi_nxt        = wi_r;
    pos_nxt       = pos_r;
    kind_nxt      = kind_r;
    win_nxt       = win_r;
    neg_start_nxt = neg_start_r;
    rem_nxt       = rem_r;
    step_nxt      = step_r;
    iss_nxt       = iss_r;
    rd_vld_nxt    = 1'b0;
    acc_nxt       = acc_r;
    dvd_nxt       = dvd_r;
    quo_nxt       = quo_r;
    drem_nxt      = drem_r;
    neg_nxt       = neg_r;
    err_nxt       = err_r;
    q_pop         = 1'b0;
    mem_we        = 1'b0;
    mem_wa        = clr_cnt_r;
    mem_wd        = cfg.fill_value;
    load_out      = 1'b0;

    // refill sweep, one entry a cycle
    if (clr_r) begin
      mem_we      = 1'b1;
      clr_cnt_nxt = clr_cnt_r + 1'b1;
      if (clr_cnt_r == IW'(DEPTH - 1)) begin
        clr_nxt     = 1'b0;
        clr_cnt_nxt = '0;
      end
    end else if (cfg.refill) begin
      clr_nxt     = 1'b1;
      clr_cnt_nxt = '0;
    end

    case (state_r)
      S_IDLE: begin
        if (!clr_r && !cfg.refill && q_valid) begin
          q_pop = 1'b1;
          if (q_data.op == wsa_pkg::OP_PUSH) begin
            wi_nxt = wi_inc;
            mem_we = 1'b1;
            mem_wa = wi_inc;
            mem_wd = q_data.sample;
          end else if (q_data.win_err) begin
            err_nxt   = 1'b1;
            state_nxt = S_RES;
          end else begin
            err_nxt       = 1'b0;
            kind_nxt      = q_data.average_kind;
            win_nxt       = q_data.window_length;
            neg_start_nxt = q_data.start_index[11];
            rem_nxt       = q_data.start_index[11] ? 12'(-q_data.start_index)
                                                   : 12'(q_data.start_index);
            step_nxt      = 5'd11;
            state_nxt     = S_RED;
          end
        end
      end
      S_RED: begin
        rem_nxt  = red_rem;
        step_nxt = step_r - 1'b1;
        if (step_r == 5'd0) begin
          pos_nxt   = (neg_start_r && red_rem != 12'd0) ?
                      IW'(32'(DEPTH) - {20'd0, red_rem}) : IW'(red_rem);
          iss_nxt   = '0;
          acc_nxt   = '0;
          state_nxt = S_SUM;
        end
      end
      S_SUM: begin
        if (rd_vld_r) begin
          acc_nxt = acc_r + 29'(term);
        end
        if (iss_r != win_r) begin
          iss_nxt    = iss_r + 1'b1;
          pos_nxt    = pos_inc;
          rd_vld_nxt = 1'b1;
        end else if (!rd_vld_r) begin
          neg_nxt   = acc_r[28];
          dvd_nxt   = acc_r[28] ? 28'(-acc_r) : 28'(acc_r);
          drem_nxt  = '0;
          quo_nxt   = '0;
          step_nxt  = 5'd27;
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        dvd_nxt  = dvd_r << 1;
        step_nxt = step_r - 1'b1;
        if (dshift >= {2'b00, win_r}) begin
          drem_nxt = 12'(dshift - {2'b00, win_r});
          quo_nxt  = {quo_r[26:0], 1'b1};
        end else begin
          drem_nxt = dshift[11:0];
          quo_nxt  = {quo_r[26:0], 1'b0};
        end
        if (step_r == 5'd0) begin
          state_nxt = S_RES;
        end
      end
      S_RES: begin
        if (slot_free) begin
          load_out  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      clr_r       <= 1'b1;
      clr_cnt_r   <= '0;
      wi_r        <= '0;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      clr_r     <= clr_nxt;
      clr_cnt_r <= clr_cnt_nxt;
      wi_r      <= wi_nxt;
      rd_vld_r  <= rd_vld_nxt;
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    pos_r       <= pos_nxt;
    kind_r      <= kind_nxt;
    win_r       <= win_nxt;
    neg_start_r <= neg_start_nxt;
    rem_r       <= rem_nxt;
    step_r      <= step_nxt;
    iss_r       <= iss_nxt;
    acc_r       <= acc_nxt;
    dvd_r       <= dvd_nxt;
    quo_r       <= quo_nxt;
    drem_r      <= drem_nxt;
    neg_r       <= neg_nxt;
    err_r       <= err_nxt;
    if (load_out) begin
      mean_r   <= mean_val;
      oerr_r   <= err_r;
      newest_r <= 10'(wi_r);
    end
  end

  // ring memory, registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rdata_r <= mem[pos_r];
  end

  assign out_valid        = out_valid_r;
  assign out_window_mean  = mean_r;
  assign out_window_error = oerr_r;
  assign out_newest_index = newest_r;

  // nothing leaves the idle state while the ring is being refilled
  a_clr_idle: assert property (@(posedge clk) disable iff (!rst_n)
    clr_r |-> (state_r == S_IDLE))
    else $error("sequencer busy during refill");

  // reads issued never exceed the window
  a_iss_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SUM) |-> (iss_r <= win_r))
    else $error("window read count overrun");

  // a finished result always reaches the output register
  a_load: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RES && slot_free) |=> out_valid_r)
    else $error("result not loaded");

  // queue is only drained from idle
  a_pop: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> (state_r == S_IDLE && !clr_r))
    else $error("pop outside idle");

endmodule

/* rtl/windowed_sample_average.sv */
// windowed_sample_average: top level; APB register file plus front, queue
// and execution side. Depends on wsa_pkg, wsa_front, wsa_queue, wsa_back.
//
//   channel   direction  handshake            payload
//   in_*      input      in_valid/in_ready    op, sample, start_index, window_length, average_kind
//   out_*     output     out_valid/out_ready  window_mean, window_error, newest_index
//   APB       config     psel/penable/pready  paddr, pwdata, prdata
//
// A push is written to the ring straight from idle; a query runs
// 12 remainder steps, one ring read per window entry and 28 divide steps.
// After reset and after each fill_value write the ring is swept at one entry
// a cycle; no request is accepted during the sweep. The two-entry queue and
// the output register let either side stall alone.
module windowed_sample_average #(
  parameter int DEPTH = 1024
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_op,
  input  logic signed [15:0] in_sample,
  input  logic signed [11:0] in_start_index,
  input  logic [10:0]        in_window_length,
  input  logic [1:0]         in_average_kind,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] out_window_mean,
  output logic               out_window_error,
  output logic [9:0]         out_newest_index,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  logic signed [15:0] ref_r;
  logic signed [15:0] fill_r;
  logic               wr_en;
  wsa_pkg::cfg_t      cfg;
  logic               clearing, q_full, q_push, q_pop, q_valid;
  wsa_pkg::cmd_t      q_in, q_out;

  // register file
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ref_r  <= wsa_pkg::LEVEL_ONE;
      fill_r <= wsa_pkg::LEVEL_ONE;
    end else if (wr_en) begin
      if (paddr[2] == wsa_pkg::REG_REFERENCE) begin
        ref_r <= pwdata[15:0];
      end else begin
        fill_r <= pwdata[15:0];
      end
    end
  end

  assign prdata = (paddr[2] == wsa_pkg::REG_REFERENCE) ? {16'd0, ref_r} : {16'd0, fill_r};

  always_comb begin
    cfg.reference_level = ref_r;
    cfg.fill_value      = fill_r;
    cfg.refill          = 1'b0;
  end

  // refill request registered so the sweep uses the new fill value
  logic refill_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      refill_r <= 1'b0;
    end else begin
      refill_r <= wr_en && (paddr[2] == wsa_pkg::REG_FILL);
    end
  end

  wsa_pkg::cfg_t cfg_b;
  always_comb begin
    cfg_b        = cfg;
    cfg_b.refill = refill_r;
  end

  wsa_front #(.DEPTH(DEPTH)) u_front (
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_op            (in_op),
    .in_sample        (in_sample),
    .in_start_index   (in_start_index),
    .in_window_length (in_window_length),
    .in_average_kind  (in_average_kind),
    .clearing         (clearing || refill_r),
    .q_full           (q_full),
    .q_push           (q_push),
    .q_data           (q_in)
  );

  wsa_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .valid     (q_valid),
    .pop_data  (q_out)
  );

  wsa_back #(.DEPTH(DEPTH)) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg              (cfg_b),
    .q_valid          (q_valid),
    .q_data           (q_out),
    .q_pop            (q_pop),
    .clearing         (clearing),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_window_mean  (out_window_mean),
    .out_window_error (out_window_error),
    .out_newest_index (out_newest_index)
  );

endmodule

/* bench/tb_windowed_sample_average.sv */
// tb_windowed_sample_average: self-checking bench for windowed_sample_average.
// Depends on wsa_pkg and the RTL; a directed table, then random requests.
module tb_windowed_sample_average;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RING_DEPTH   = 1024;
  localparam int SETTLE_CYCLES = 120;

  // one expected query answer
  typedef struct {
    logic signed [15:0] mean;
    logic               err;
    logic [9:0]         newest;
  } window_answer_t;

  // directed row: either a register write or a request
  typedef struct {
    bit                 is_reg;
    logic               reg_idx;
    logic signed [15:0] reg_val;
    logic               op;
    logic signed [15:0] sample;
    logic signed [11:0] start_index;
    logic [10:0]        window_length;
    logic [1:0]         kind;
    bit                 known;
    logic signed [15:0] exp_mean;
    logic               exp_err;
    logic [9:0]         exp_newest;
  } directed_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic in_op = wsa_pkg::OP_PUSH;
  logic signed [15:0] in_sample = '0;
  logic signed [11:0] in_start_index = '0;
  logic [10:0] in_window_length = '0;
  logic [1:0] in_average_kind = wsa_pkg::KIND_PLAIN;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [15:0] out_window_mean;
  logic out_window_error;
  logic [9:0] out_newest_index;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  // model state of the ring and registers
  logic signed [15:0] ring_model [RING_DEPTH];
  logic [9:0]         newest_pos;
  logic signed [15:0] ref_level_model;
  logic signed [15:0] fill_model;

  window_answer_t pending_answers[$];
  int errors = 0;
  int gap_pct = 0;
  int stall_pct = 0;

  windowed_sample_average DUT (.*);

  always #5 clk = ~clk;

  initial begin
    #200ms;
    $display("FAIL");
    $finish;
  end

  function automatic void refill_ring_model();
    for (int i = 0; i < RING_DEPTH; i++) ring_model[i] = fill_model;
  endfunction

  // windowed mean as the block computes it
  function automatic window_answer_t average_window(logic signed [11:0] start_index,
                                                    logic [10:0] win, logic [1:0] kind);
    window_answer_t a;
    longint sum, v, m;
    int s;
    a.newest = newest_pos;
    a.err = (win == 0) || (win > RING_DEPTH);
    a.mean = '0;
    if (!a.err) begin
      s = int'(start_index) % RING_DEPTH;
      if (s < 0) s += RING_DEPTH;
      sum = 0;
      for (int i = 0; i < win; i++) begin
        v = ring_model[s];
        if (kind == wsa_pkg::KIND_OFFSET) v -= ref_level_model;
        else if (kind == wsa_pkg::KIND_DEV) begin
          v -= ref_level_model;
          if (v < 0) v = -v;
        end
        sum += v;
        s = (s + 1) % RING_DEPTH;
      end
      m = sum / longint'(win);
      if (m > 32767) m = 32767;
      if (m < -32768) m = -32768;
      a.mean = m[15:0];
    end
    return a;
  endfunction

  // drive one request; returns once accepted, valid left high
  task automatic send_request(logic op, logic signed [15:0] smp, logic signed [11:0] st,
                              logic [10:0] win, logic [1:0] kind);
    while ($urandom_range(99) < gap_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_op = op;
    in_sample = smp;
    in_start_index = st;
    in_window_length = win;
    in_average_kind = kind;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  task automatic send_checked(logic op, logic signed [15:0] smp, logic signed [11:0] st,
                              logic [10:0] win, logic [1:0] kind);
    send_request(op, smp, st, win, kind);
    if (op == wsa_pkg::OP_PUSH) begin
      newest_pos = newest_pos + 10'd1;
      ring_model[newest_pos] = smp;
    end else begin
      pending_answers.push_back(average_window(st, win, kind));
    end
  endtask

  // register write once the block has drained
  task automatic write_register(logic idx, logic signed [15:0] val);
    in_valid = 1'b0;
    while (pending_answers.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = (idx == wsa_pkg::REG_FILL) ? 3'd4 : 3'd0;
    pwdata = {{16{val[15]}}, val};
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    if (idx == wsa_pkg::REG_REFERENCE) ref_level_model = val;
    else begin
      fill_model = val;
      refill_ring_model();
    end
  endtask

  // receiver: random stalls, check each answer against the oldest expectation
  always @(negedge clk) out_ready = ($urandom_range(99) >= stall_pct);

  always @(posedge clk) begin
    window_answer_t e;
    if (rst_n && out_valid && out_ready) begin
      if (pending_answers.size() == 0) begin
        $display("%0t: unexpected answer mean=%0d err=%0d newest=%0d", $time,
                 out_window_mean, out_window_error, out_newest_index);
        errors++;
      end else begin
        e = pending_answers.pop_front();
        if (out_window_mean !== e.mean) begin
          $display("%0t: window_mean exp %0d got %0d", $time, e.mean, out_window_mean);
          errors++;
        end
        if (out_window_error !== e.err) begin
          $display("%0t: window_error exp %0d got %0d", $time, e.err, out_window_error);
          errors++;
        end
        if (out_newest_index !== e.newest) begin
          $display("%0t: newest_index exp %0d got %0d", $time, e.newest, out_newest_index);
          errors++;
        end
      end
    end
  end

  function automatic directed_row_t req(logic op, int smp, int st, int win, logic [1:0] kind);
    directed_row_t r = '{default: '0};
    r.op = op;
    r.sample = smp[15:0];
    r.start_index = st[11:0];
    r.window_length = win[10:0];
    r.kind = kind;
    return r;
  endfunction

  function automatic directed_row_t req_known(int st, int win, logic [1:0] kind,
                                              int m, logic err);
    directed_row_t r = req(wsa_pkg::OP_QUERY, 0, st, win, kind);
    r.known = 1'b1;
    r.exp_mean = m[15:0];
    r.exp_err = err;
    r.exp_newest = '0;
    return r;
  endfunction

  function automatic directed_row_t reg_row(logic idx, int val);
    directed_row_t r = '{default: '0};
    r.is_reg = 1'b1;
    r.reg_idx = idx;
    r.reg_val = val[15:0];
    return r;
  endfunction

  function automatic logic signed [15:0] pick_sample();
    case ($urandom_range(7))
      0: return 16'sh7FFF;
      1: return 16'sh8000;
      2: return 16'(ref_level_model + $signed(16'($urandom_range(64))) - 16'sd32);
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [10:0] pick_window();
    int r = $urandom_range(99);
    if (r < 80) return 11'($urandom_range(32, 1));
    if (r < 86) return 11'($urandom_range(RING_DEPTH, 33));
    if (r < 89) return 11'(RING_DEPTH);
    if (r < 94) return 11'd0;
    return 11'($urandom_range(2047, RING_DEPTH + 1));
  endfunction

  directed_row_t plan[$];
  int gap_set[4] = '{0, 57, 0, 37};
  int stall_set[4] = '{0, 0, 57, 37};

  initial begin
    directed_row_t r;
    window_answer_t e;
    ref_level_model = wsa_pkg::LEVEL_ONE;
    fill_model = wsa_pkg::LEVEL_ONE;
    newest_pos = '0;
    refill_ring_model();
    repeat (2) @(negedge clk);
    rst_n = 1'b1;

    // directed table: reset contents, bad windows, wrap, saturation, refill
    plan = '{
      req_known(0, 1, wsa_pkg::KIND_PLAIN, 4096, 1'b0),
      req_known(0, 0, wsa_pkg::KIND_PLAIN, 0, 1'b1),
      req_known(0, 1025, wsa_pkg::KIND_DEV, 0, 1'b1),
      req_known(-1, 2047, wsa_pkg::KIND_OFFSET, 0, 1'b1),
      req_known(0, 1024, wsa_pkg::KIND_OFFSET, 0, 1'b0),
      req_known(-2048, 1024, wsa_pkg::KIND_DEV, 0, 1'b0),
      req_known(2047, 3, wsa_pkg::KIND_SPARE, 4096, 1'b0),
      req(wsa_pkg::OP_PUSH, 32767, 0, 0, wsa_pkg::KIND_PLAIN),
      req(wsa_pkg::OP_PUSH, -32768, 0, 0, wsa_pkg::KIND_PLAIN),
      req(wsa_pkg::OP_PUSH, 0, 0, 0, wsa_pkg::KIND_PLAIN),
      req(wsa_pkg::OP_QUERY, 0, 1, 3, wsa_pkg::KIND_PLAIN),
      reg_row(wsa_pkg::REG_REFERENCE, -32768),
      req(wsa_pkg::OP_QUERY, 0, 1, 1, wsa_pkg::KIND_OFFSET),
      req(wsa_pkg::OP_QUERY, 0, 1, 2, wsa_pkg::KIND_DEV),
      reg_row(wsa_pkg::REG_REFERENCE, 32767),
      req(wsa_pkg::OP_QUERY, 0, 2, 1, wsa_pkg::KIND_OFFSET),
      req(wsa_pkg::OP_QUERY, 0, 1023, 4, wsa_pkg::KIND_DEV),
      reg_row(wsa_pkg::REG_FILL, -32768),
      req(wsa_pkg::OP_QUERY, 0, 500, 1024, wsa_pkg::KIND_PLAIN),
      req(wsa_pkg::OP_PUSH, -1, 0, 0, wsa_pkg::KIND_PLAIN),
      req(wsa_pkg::OP_QUERY, 0, -2048, 1024, wsa_pkg::KIND_DEV),
      reg_row(wsa_pkg::REG_FILL, 32767),
      reg_row(wsa_pkg::REG_REFERENCE, 0),
      req(wsa_pkg::OP_QUERY, 0, 5, 1024, wsa_pkg::KIND_PLAIN),
      req(wsa_pkg::OP_QUERY, 0, -5, 7, wsa_pkg::KIND_OFFSET)
    };
    foreach (plan[i]) begin
      r = plan[i];
      if (r.is_reg) write_register(r.reg_idx, r.reg_val);
      else if (r.known) begin
        send_request(r.op, r.sample, r.start_index, r.window_length, r.kind);
        e.mean = r.exp_mean;
        e.err = r.exp_err;
        e.newest = r.exp_newest;
        pending_answers.push_back(e);
      end else send_checked(r.op, r.sample, r.start_index, r.window_length, r.kind);
    end

    // random phases, each under new register settings and idling
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: write_register(wsa_pkg::REG_REFERENCE, 16'sh8000);
        1: write_register(wsa_pkg::REG_REFERENCE, 16'sh7FFF);
        default: write_register(wsa_pkg::REG_REFERENCE, 16'($urandom));
      endcase
      write_register(wsa_pkg::REG_FILL, (ph == 3) ? 16'sh7FFF : 16'($urandom));
      gap_pct = gap_set[ph];
      stall_pct = stall_set[ph];
      for (int n = 0; n < 420; n++) begin
        if ($urandom_range(99) < 55)
          send_checked(wsa_pkg::OP_PUSH, pick_sample(), 12'($urandom), 11'($urandom),
                       2'($urandom));
        else
          send_checked(wsa_pkg::OP_QUERY, 16'($urandom), 12'($urandom), pick_window(),
                       2'($urandom_range(3)));
      end
    end

    in_valid = 1'b0;
    while (pending_answers.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (errors == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end
endmodule
